[hw/rtl/qee_pkg.sv]
// Package for the quadrature encoder event block: beat types, widths,
// register map and the transition table. No dependencies.

package qee_pkg;

	localparam int TransitionsPerDetent = 4;
	localparam logic [7:0] StepValueReset = 8'd1;
	localparam logic [15:0] ReleaseDelayReset = 16'd50;

	localparam int InTdataW = 40;
	localparam int OutTdataW = 80;
	localparam int ApbAddrW = 3;
	localparam int ApbDataW = 32;

	typedef enum logic {
		REG_STEP_VALUE = 1'b0,
		REG_RELEASE_DELAY = 1'b1
	} qee_reg_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_CW = 2'd1,
		DIR_CCW = 2'd2
	} qee_dir_t;

	typedef struct packed {
		logic quad_a;
		logic quad_b;
		logic button_level;
		logic [31:0] now_ms;
		logic clear_position;
	} qee_item_t;

	typedef struct packed {
		logic event_valid;
		logic event_kind;
		logic signed [8:0] rotation_delta;
		logic signed [31:0] position;
		logic active;
		logic signed [31:0] current_position;
	} qee_result_t;

	function automatic qee_dir_t qee_dir(input logic [1:0] last_pair, input logic [1:0] pair);
		qee_dir_t d;
		unique case ({last_pair, pair})
			4'b00_01: d = DIR_CW;
			4'b00_10: d = DIR_CCW;
			4'b01_00: d = DIR_CCW;
			4'b01_11: d = DIR_CW;
			4'b10_00: d = DIR_CW;
			4'b10_11: d = DIR_CCW;
			4'b11_01: d = DIR_CCW;
			4'b11_10: d = DIR_CW;
			default: d = DIR_NONE;
		endcase
		return d;
	endfunction

endpackage

[hw/rtl/quadrature_encoder_events.sv]
// Top level of the quadrature encoder event block: input stage, APB
// registers, result register. Depends on qee_pkg and qee_core.
//
//  channel  | dir | payload
//  s_axis   | in  | tdata: quad_a, quad_b, button_level, now_ms, clear_position
//  m_axis   | out | tdata: event_valid, rotation_delta, position, active,
//           |     |        current_position; tuser: event_kind
//  apb      | in  | step_value at 0x0, release_delay at 0x4
//
// One beat in and one beat out per clock cycle while the output is not stalled; a result
// beat is registered first in the input stage and then in the result register.
// Decoder state is updated in the single cycle a sample moves from the input
// stage to the result register. Reset empties both stages, returns the decoder
// state to its idle values and loads the register defaults.
// A stalled output holds its beat while one more sample waits in the input stage.

module quadrature_encoder_events #(
	parameter int TRANSITIONS_PER_DETENT = qee_pkg::TransitionsPerDetent
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// quad_a, quad_b, button_level, now_ms[31:0], clear_position, zero fill
	input  logic [qee_pkg::InTdataW-1:0]   s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// event_valid, rotation_delta[8:0], position[31:0], active,
	// current_position[31:0], zero fill
	output logic [qee_pkg::OutTdataW-1:0]  m_axis_tdata,
	// event_kind
	output logic                           m_axis_tuser,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [qee_pkg::ApbAddrW-1:0]   paddr,
	input  logic [qee_pkg::ApbDataW-1:0]   pwdata,
	output logic [qee_pkg::ApbDataW-1:0]   prdata,
	output logic                           pready
);
	import qee_pkg::*;

	logic in_vld_s1;
	qee_item_t item_s1;
	logic out_vld_q;
	qee_result_t res_q;
	qee_result_t res;
	logic advance;
	logic [7:0] step_q;
	logic [15:0] delay_q;
	qee_reg_t reg_sel;

	assign advance = in_vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !in_vld_s1 || !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.quad_a <= s_axis_tdata[0];
			item_s1.quad_b <= s_axis_tdata[1];
			item_s1.button_level <= s_axis_tdata[2];
			item_s1.now_ms <= s_axis_tdata[34:3];
			item_s1.clear_position <= s_axis_tdata[35];
		end
	end

	qee_core #(
		.TRANSITIONS_PER_DETENT(TRANSITIONS_PER_DETENT)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.en(advance),
		.item(item_s1),
		.step_value(step_q),
		.release_delay(delay_q),
		.result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || m_axis_tready) begin
			out_vld_q <= in_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser = res_q.event_kind;
	assign m_axis_tdata = {5'd0, res_q.current_position, res_q.active, res_q.position,
		res_q.rotation_delta, res_q.event_valid};

	assign reg_sel = qee_reg_t'(paddr[2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= StepValueReset;
			delay_q <= ReleaseDelayReset;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_STEP_VALUE: step_q <= pwdata[7:0];
				REG_RELEASE_DELAY: delay_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_STEP_VALUE: prdata = {24'd0, step_q};
			REG_RELEASE_DELAY: prdata = {16'd0, delay_q};
			default: prdata = '0;
		endcase
	end

endmodule

[hw/rtl/qee_core.sv]
// Decoder state and per-sample event logic of the quadrature encoder block.
// Depends on qee_pkg.

module qee_core #(
	parameter int TRANSITIONS_PER_DETENT = qee_pkg::TransitionsPerDetent
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  qee_pkg::qee_item_t item,
	input  logic [7:0]         step_value,
	input  logic [15:0]        release_delay,
	output qee_pkg::qee_result_t result
);
	import qee_pkg::*;

	localparam int CntW = $clog2(TRANSITIONS_PER_DETENT + 1);
	localparam logic [CntW-1:0] CntDetent = CntW'(TRANSITIONS_PER_DETENT);

	logic [1:0] quad_q;
	logic [CntW-1:0] cnt_q;
	logic [31:0] pos_q;
	logic [31:0] last_ms_q;
	logic pend_q;
	logic button_q;

	logic [1:0] pair;
	logic [31:0] pos_clr;
	logic [31:0] pos_rot;
	logic [31:0] elapsed;
	logic rel_fire;
	logic detent;
	logic btn_chg;
	logic [CntW-1:0] cnt_inc;
	logic [CntW-1:0] cnt_n;
	logic [8:0] delta;
	qee_dir_t dir;

	always_comb begin
		pair = {item.quad_a, item.quad_b};
		pos_clr = item.clear_position ? 32'd0 : pos_q;
		elapsed = item.now_ms - last_ms_q;
		rel_fire = pend_q && (elapsed >= {16'd0, release_delay});
		dir = qee_dir(quad_q, pair);
		cnt_inc = cnt_q + CntW'(1);
		detent = 1'b0;
		cnt_n = cnt_q;
		if (pair != quad_q) begin
			if (dir == DIR_NONE) begin
				cnt_n = '0;
			end else if (cnt_inc == CntDetent) begin
				cnt_n = '0;
				detent = 1'b1;
			end else begin
				cnt_n = cnt_inc;
			end
		end
		delta = (dir == DIR_CW) ? {1'b0, step_value} : 9'd0 - {1'b0, step_value};
		pos_rot = pos_clr + {{23{delta[8]}}, delta};
		btn_chg = item.button_level != button_q;

		result = '0;
		result.current_position = detent ? pos_rot : pos_clr;
		priority if (btn_chg) begin
			result.event_valid = 1'b1;
			result.event_kind = 1'b1;
			result.active = ~item.button_level;
		end else if (detent) begin
			result.event_valid = 1'b1;
			result.rotation_delta = delta;
			result.position = pos_rot;
			result.active = 1'b1;
		end else if (rel_fire) begin
			result.event_valid = 1'b1;
			result.position = pos_clr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_q <= 2'b11;
			cnt_q <= '0;
			pos_q <= '0;
			last_ms_q <= '0;
			pend_q <= 1'b0;
			button_q <= 1'b1;
		end else if (en) begin
			quad_q <= pair;
			cnt_q <= cnt_n;
			pos_q <= detent ? pos_rot : pos_clr;
			button_q <= item.button_level;
			if (detent) begin
				last_ms_q <= item.now_ms;
				pend_q <= 1'b1;
			end else if (rel_fire) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/qee_checker.sv]
// Port-level checks for the quadrature encoder event block, bound to the
// top level. Depends on qee_pkg.

module qee_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [qee_pkg::OutTdataW-1:0] m_axis_tdata,
	input logic                          m_axis_tuser
);
	import qee_pkg::*;

	logic ev_valid;
	logic [8:0] ev_delta;
	logic [31:0] ev_pos;
	logic ev_active;
	logic [31:0] ev_cur;

	assign ev_valid = m_axis_tdata[0];
	assign ev_delta = m_axis_tdata[9:1];
	assign ev_pos = m_axis_tdata[41:10];
	assign ev_active = m_axis_tdata[42];
	assign ev_cur = m_axis_tdata[74:43];

	a_no_out_in_reset: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("Output beat shown during reset.");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Stalled output beat changed.");

	a_idle_beat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !ev_valid |->
		!m_axis_tuser && ev_delta == 9'd0 && ev_pos == 32'd0 && !ev_active)
		else $error("Beat without event carries event fields.");

	a_button_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ev_valid && m_axis_tuser |-> ev_delta == 9'd0 && ev_pos == 32'd0)
		else $error("Button event carries rotation fields.");

	a_rotation_position: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ev_valid && !m_axis_tuser |-> ev_pos == ev_cur)
		else $error("Rotation or release position differs from the position register.");

endmodule

bind quadrature_encoder_events qee_checker u_qee_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);
